@@ src/wfna_pkg.sv @@
// Shared types and constants for the worst-fit node allocator.
package wfna_pkg;

  localparam int unsigned NODE_SLOTS  = 16;
  localparam int unsigned SLOT_W      = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int unsigned CNT_W       = $clog2(NODE_SLOTS + 1);
  localparam int unsigned IDENT_W     = 32;
  localparam int unsigned MEM_W       = 40;
  localparam int unsigned TASK_W      = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MEM_W-1:0]  MAX_REQUEST_RST = 40'd17179869184;
  localparam logic [TASK_W-1:0] MAX_TASKS_RST   = 8'd8;
  localparam logic [CNT_W-1:0]  SLOTS_CNT       = CNT_W'(NODE_SLOTS);
  localparam logic [QCNT_W-1:0] QUEUE_FULL_CNT  = QCNT_W'(QUEUE_DEPTH);

  localparam logic CFG_MAX_REQUEST = 1'b0;
  localparam logic CFG_MAX_TASKS   = 1'b1;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_ALLOCATE = 2'd1,
    CMD_RELEASE  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_OVER_LIMIT = 3'd1,
    STATUS_NO_FIT     = 3'd2,
    STATUS_FULL       = 3'd3,
    STATUS_UNKNOWN    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_ALLOCATE   = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_OVER_LIMIT = 3'd3,
    OP_NOP        = 3'd4
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IDENT_W-1:0] ident;
    logic [MEM_W-1:0]   bytes;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

@@ src/worst_fit_node_allocator.sv @@
// Worst-fit node allocator top level: configuration registers and engine wiring.
// Register, over-limit and unused commands are settled straight from the idle state.
// Allocate scans all filled entries for the fitting one with most free bytes, then walks
// the table to it; release walks the table to the matching id, or to its end if unknown.
// One item at a time in the engine; a two-entry queue takes items ahead.
// Reset empties the table and loads 16 GiB and 8 tasks; done_o pulses one cycle, unstalled.
module worst_fit_node_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    command_i,
  input  logic [wfna_pkg::IDENT_W-1:0]  node_ident_i,
  input  logic [wfna_pkg::MEM_W-1:0]    mem_bytes_i,
  output logic                          done_o,
  output logic [wfna_pkg::STATUS_W-1:0] status_o,
  output logic [wfna_pkg::IDENT_W-1:0]  chosen_node_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [wfna_pkg::MEM_W-1:0]    cfg_data_i
);

  logic [wfna_pkg::MEM_W-1:0]  max_request_q;
  logic [wfna_pkg::TASK_W-1:0] max_tasks_q;
  wfna_pkg::head_t             head;
  logic                        pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_request_q <= wfna_pkg::MAX_REQUEST_RST;
      max_tasks_q   <= wfna_pkg::MAX_TASKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == wfna_pkg::CFG_MAX_REQUEST) begin
        max_request_q <= cfg_data_i;
      end else begin
        max_tasks_q <= cfg_data_i[wfna_pkg::TASK_W-1:0];
      end
    end
  end

  wfna_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .command_i     (command_i),
    .node_ident_i  (node_ident_i),
    .mem_bytes_i   (mem_bytes_i),
    .max_request_i (max_request_q),
    .pop_i         (pop),
    .head_o        (head),
    .busy_o        (busy_o)
  );

  wfna_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .max_tasks_i   (max_tasks_q),
    .pop_o         (pop),
    .done_o        (done_o),
    .status_o      (status_o),
    .chosen_node_o (chosen_node_o)
  );

endmodule

@@ src/wfna_front.sv @@
// Command intake: classify each item and queue it for the table engine.
module wfna_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   command_i,
  input  logic [wfna_pkg::IDENT_W-1:0] node_ident_i,
  input  logic [wfna_pkg::MEM_W-1:0]   mem_bytes_i,
  input  logic [wfna_pkg::MEM_W-1:0]   max_request_i,
  input  logic                         pop_i,
  output wfna_pkg::head_t              head_o,
  output logic                         busy_o
);

  wfna_pkg::item_t                     queue_q [wfna_pkg::QUEUE_DEPTH];
  logic [wfna_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [wfna_pkg::QPTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [wfna_pkg::QCNT_W-1:0]         count_q, count_d;
  logic                                push;
  logic                                pop;
  wfna_pkg::item_t                     new_item;

  function automatic logic [wfna_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
    QCNT_ONE = {{(wfna_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign busy_o = (count_q == wfna_pkg::QUEUE_FULL_CNT);
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (count_q != '0);

  always_comb begin
    new_item.ident = node_ident_i;
    new_item.bytes = mem_bytes_i;
    unique case (command_i)
      wfna_pkg::CMD_REGISTER: begin
        new_item.op = wfna_pkg::OP_REGISTER;
      end
      wfna_pkg::CMD_ALLOCATE: begin
        new_item.op = (mem_bytes_i > max_request_i) ? wfna_pkg::OP_OVER_LIMIT
                                                    : wfna_pkg::OP_ALLOCATE;
      end
      wfna_pkg::CMD_RELEASE: begin
        new_item.op = wfna_pkg::OP_RELEASE;
      end
      default: begin
        new_item.op = wfna_pkg::OP_NOP;
      end
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_ONE(push) - QCNT_ONE(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = queue_q[rd_ptr_q];

endmodule

@@ src/wfna_back.sv @@
// Table engine: node table, worst-fit scan, id lookup and result register.
module wfna_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wfna_pkg::head_t               head_i,
  input  logic [wfna_pkg::TASK_W-1:0]   max_tasks_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic [wfna_pkg::STATUS_W-1:0] status_o,
  output logic [wfna_pkg::IDENT_W-1:0]  chosen_node_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIND = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  logic [wfna_pkg::IDENT_W-1:0]   entry_ident_q [wfna_pkg::NODE_SLOTS];
  logic [wfna_pkg::MEM_W-1:0]     entry_free_q  [wfna_pkg::NODE_SLOTS];
  logic [wfna_pkg::TASK_W-1:0]    entry_task_q  [wfna_pkg::NODE_SLOTS];
  logic [wfna_pkg::CNT_W-1:0]     used_q, used_d;
  logic [wfna_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [wfna_pkg::MEM_W-1:0]     best_q, best_d;
  logic                           found_q, found_d;
  logic [wfna_pkg::IDENT_W-1:0]   target_q, target_d;
  wfna_pkg::item_t                cur_q, cur_d;
  logic                           done_q, done_d;
  wfna_pkg::status_e              status_q, status_d;
  logic [wfna_pkg::IDENT_W-1:0]   chosen_q, chosen_d;

  logic                           wr_en;
  logic [wfna_pkg::SLOT_W-1:0]    wr_slot;
  logic [wfna_pkg::IDENT_W-1:0]   wr_ident;
  logic [wfna_pkg::MEM_W-1:0]     wr_free;
  logic [wfna_pkg::TASK_W-1:0]    wr_task;
  logic                           ident_wr;

  logic [wfna_pkg::SLOT_W-1:0]    slot;
  logic [wfna_pkg::IDENT_W-1:0]   rd_ident;
  logic [wfna_pkg::MEM_W-1:0]     rd_free;
  logic [wfna_pkg::TASK_W-1:0]    rd_task;
  logic [wfna_pkg::MEM_W:0]       sum;
  logic [wfna_pkg::MEM_W-1:0]     free_sub;
  logic [wfna_pkg::MEM_W-1:0]     free_add;
  logic [wfna_pkg::TASK_W-1:0]    task_inc;
  logic [wfna_pkg::TASK_W-1:0]    task_dec;

  assign slot     = idx_q[wfna_pkg::SLOT_W-1:0];
  assign rd_ident = entry_ident_q[slot];
  assign rd_free  = entry_free_q[slot];
  assign rd_task  = entry_task_q[slot];
  assign sum      = {1'b0, rd_free} + {1'b0, cur_q.bytes};
  assign free_sub = (rd_free >= cur_q.bytes) ? rd_free - cur_q.bytes : '0;
  assign free_add = sum[wfna_pkg::MEM_W] ? '1 : sum[wfna_pkg::MEM_W-1:0];
  assign task_inc = (rd_task == '1) ? rd_task : rd_task + 1'b1;
  assign task_dec = (rd_task == '0) ? rd_task : rd_task - 1'b1;

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    idx_d    = idx_q;
    best_d   = best_q;
    found_d  = found_q;
    target_d = target_q;
    cur_d    = cur_q;
    done_d   = 1'b0;
    status_d = status_q;
    chosen_d = chosen_q;
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    ident_wr = 1'b0;
    wr_slot  = slot;
    wr_ident = head_i.item.ident;
    wr_free  = rd_free;
    wr_task  = rd_task;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          cur_d    = head_i.item;
          idx_d    = '0;
          best_d   = '0;
          found_d  = 1'b0;
          target_d = head_i.item.ident;
          chosen_d = '0;
          unique case (head_i.item.op)
            wfna_pkg::OP_REGISTER: begin
              done_d = 1'b1;
              if (used_q == wfna_pkg::SLOTS_CNT) begin
                status_d = wfna_pkg::STATUS_FULL;
              end else begin
                status_d = wfna_pkg::STATUS_OK;
                wr_en    = 1'b1;
                ident_wr = 1'b1;
                wr_slot  = used_q[wfna_pkg::SLOT_W-1:0];
                wr_free  = head_i.item.bytes;
                wr_task  = '0;
                used_d   = used_q + 1'b1;
              end
            end
            wfna_pkg::OP_ALLOCATE: begin
              state_d = ST_SCAN;
            end
            wfna_pkg::OP_RELEASE: begin
              state_d = ST_FIND;
            end
            wfna_pkg::OP_OVER_LIMIT: begin
              done_d   = 1'b1;
              status_d = wfna_pkg::STATUS_OVER_LIMIT;
            end
            default: begin
              done_d   = 1'b1;
              status_d = wfna_pkg::STATUS_OK;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_q == used_q) begin
          idx_d = '0;
          if (found_q) begin
            state_d = ST_FIND;
          end else begin
            state_d  = ST_IDLE;
            done_d   = 1'b1;
            status_d = wfna_pkg::STATUS_NO_FIT;
            chosen_d = '0;
          end
        end else begin
          if (rd_free >= cur_q.bytes && rd_task < max_tasks_i && rd_free > best_q) begin
            best_d   = rd_free;
            target_d = rd_ident;
            found_d  = 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FIND: begin
        if (idx_q == used_q) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = wfna_pkg::STATUS_UNKNOWN;
          chosen_d = '0;
        end else if (rd_ident == target_q) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = wfna_pkg::STATUS_OK;
          wr_en    = 1'b1;
          if (cur_q.op == wfna_pkg::OP_ALLOCATE) begin
            wr_free  = free_sub;
            wr_task  = task_inc;
            chosen_d = target_q;
          end else begin
            wr_free  = free_add;
            wr_task  = task_dec;
            chosen_d = '0;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    target_q <= target_d;
    cur_q    <= cur_d;
    status_q <= status_d;
    chosen_q <= chosen_d;
    if (wr_en) begin
      entry_free_q[wr_slot] <= wr_free;
      entry_task_q[wr_slot] <= wr_task;
      if (ident_wr) begin
        entry_ident_q[wr_slot] <= wr_ident;
      end
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign chosen_node_o = chosen_q;

endmodule
